[design/twpa_pkg.sv]
package twpa_pkg;

   // window geometry default
   localparam int DEF_WINDOW_DEPTH = 64;

   // item and register field widths
   localparam int POS_W     = 32;
   localparam int ELAPSED_W = 16;
   localparam int TIME_W    = 32;
   localparam int MODE_W    = 1;
   localparam int MINIV_W   = 16;
   localparam int MAXCNT_W  = 7;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 16;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_INTERVAL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_COUNT    = 2'd2;

   // configuration reset values
   localparam logic [MODE_W-1:0]   MODE_RESET         = 1'b0;
   localparam logic [MINIV_W-1:0]  MIN_INTERVAL_RESET = 16'd50;
   localparam logic [MAXCNT_W-1:0] MAX_COUNT_RESET    = 7'd50;

   // mode codes
   localparam logic [MODE_W-1:0] MODE_AVERAGE    = 1'b0;
   localparam logic [MODE_W-1:0] MODE_FIRST_ONLY = 1'b1;

   // command codes
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

endpackage

[design/twpa_ram.sv]
module twpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

[design/twpa_div.sv]
module twpa_div #(
   parameter int SUM_W = 38,
   parameter int CNT_W = 7
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [SUM_W-1:0]     dividend,
   input  logic        [CNT_W-1:0]     divisor,
   output logic                        done,
   output logic signed [twpa_pkg::POS_W-1:0] quotient
);
   import twpa_pkg::*;

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              neg_ff, neg_in;
   logic [SUM_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  rem_ff, rem_in;
   logic [CNT_W-1:0]  den_ff, den_in;

   logic [CNT_W:0]    trial;
   logic [CNT_W:0]    trial_sub;
   logic              fits;
   logic [POS_W-1:0]  q_low;

   // one restoring step per cycle, magnitude then sign
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      neg_in  = neg_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      trial_sub = trial - {1'b0, den_ff};
      fits      = (trial >= {1'b0, den_ff});
      if (start) begin
         busy_in = 1'b1;
         step_in = STEP_W'(SUM_W);
         neg_in  = dividend[SUM_W-1];
         quo_in  = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         den_in  = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[SUM_W-2:0], fits};
         rem_in  = fits ? trial_sub[CNT_W-1:0] : trial[CNT_W-1:0];
         step_in = step_ff - 1'b1;
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      neg_ff <= neg_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   // apply sign to the low word of the magnitude
   assign q_low    = quo_ff[POS_W-1:0];
   assign quotient = neg_ff ? (~q_low + 1'b1) : q_low;
   assign done     = done_ff;

endmodule

[design/timed_window_position_average.sv]
// Channel | Dir | Handshake          | Payload (lowest bit first)
// req     | in  | req_tvalid/tready  | tuser: cmd; tdata: elapsed, target_x, target_y
// rsp     | out | rsp_tvalid/tready  | tuser: accepted; tdata: avg_x, avg_y
// csr     | in  | csr_we             | csr_index, csr_wdata (no read-back)
//
// A push runs the bit-per-cycle divide of the window sum (SUM_W bits, 38 at depth
// 64) by the entry count before the next beat is taken. A push that samples into a
// non-empty window first drops the oldest entries, D of them (usually 0 or 1); each
// drop is one memory read and one subtract. A clear skips the divide. Reset is
// synchronous; no clearing pass is needed. A finished result waits in the output
// register while the next beat is taken.
module timed_window_position_average #(
   parameter int WINDOW_DEPTH = twpa_pkg::DEF_WINDOW_DEPTH
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [79:0]                         req_tdata,  // elapsed, target_x, target_y
   input  logic                                req_tuser,  // cmd
   // response channel
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [63:0]                         rsp_tdata,  // avg_x, avg_y
   output logic                                rsp_tuser,  // accepted
   // configuration
   input  logic                                csr_we,
   input  logic [twpa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [twpa_pkg::CSR_DAT_W-1:0]      csr_wdata
);
   import twpa_pkg::*;

   localparam int IDX_W = $clog2(WINDOW_DEPTH);
   localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W = POS_W + IDX_W;
   localparam int AW    = IDX_W + 1;
   localparam int LIM_W = (CNT_W > MAXCNT_W) ? CNT_W : MAXCNT_W;

   // sequencer states
   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_EVAL     = 4'd1;
   localparam logic [3:0] ST_TIME     = 4'd2;
   localparam logic [3:0] ST_TRIM_CHK = 4'd3;
   localparam logic [3:0] ST_TRIM_ACC = 4'd4;
   localparam logic [3:0] ST_APPEND   = 4'd5;
   localparam logic [3:0] ST_DIV_GO   = 4'd6;
   localparam logic [3:0] ST_DIV_WAIT = 4'd7;
   localparam logic [3:0] ST_WAIT_OUT = 4'd8;

   // control state
   logic [3:0]              state_ff, state_in;
   logic [MODE_W-1:0]       mode_ff, mode_in;
   logic [MINIV_W-1:0]      min_iv_ff, min_iv_in;
   logic [MAXCNT_W-1:0]     max_cnt_ff, max_cnt_in;
   logic [CNT_W-1:0]        count_ff, count_in;
   logic [IDX_W-1:0]        oldest_ff, oldest_in;
   logic signed [SUM_W-1:0] sum_x_ff, sum_x_in;
   logic signed [SUM_W-1:0] sum_y_ff, sum_y_in;
   logic [TIME_W-1:0]       cur_ff, cur_in;
   logic [TIME_W-1:0]       last_ff, last_in;
   logic                    rsp_valid_ff, rsp_valid_in;

   // item and result payload
   logic                    cmd_ff, cmd_in;
   logic [ELAPSED_W-1:0]    elapsed_ff, elapsed_in;
   logic [POS_W-1:0]        x_ff, x_in;
   logic [POS_W-1:0]        y_ff, y_in;
   logic                    acc_ff, acc_in;
   logic [POS_W-1:0]        res_x_ff, res_x_in;
   logic [POS_W-1:0]        res_y_ff, res_y_in;
   logic [POS_W-1:0]        rsp_x_ff, rsp_x_in;
   logic [POS_W-1:0]        rsp_y_ff, rsp_y_in;
   logic                    rsp_acc_ff, rsp_acc_in;

   // memory and divider hookup
   logic                    ram_we;
   logic [IDX_W-1:0]        ram_waddr;
   logic [2*POS_W-1:0]      ram_rdata;
   logic [AW-1:0]           app_idx;
   logic                    div_start;
   logic                    div_x_done;
   logic                    div_y_done;
   logic [POS_W-1:0]        div_x_q;
   logic [POS_W-1:0]        div_y_q;

   // helpers
   logic [LIM_W-1:0]        mc_wide;
   logic [LIM_W-1:0]        lim_wide;
   logic [CNT_W-1:0]        limit;
   logic [TIME_W-1:0]       time_gap;
   logic signed [SUM_W-1:0] x_ext, y_ext, old_x_ext, old_y_ext;
   logic                    req_fire;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // clamp the window limit to 1..depth
   assign mc_wide  = LIM_W'(max_cnt_ff);
   assign lim_wide = (mc_wide == '0) ? LIM_W'(1) :
                     (mc_wide > LIM_W'(WINDOW_DEPTH)) ? LIM_W'(WINDOW_DEPTH) : mc_wide;
   assign limit    = lim_wide[CNT_W-1:0];

   assign time_gap  = cur_ff - last_ff;
   assign x_ext     = {{(SUM_W-POS_W){x_ff[POS_W-1]}}, x_ff};
   assign y_ext     = {{(SUM_W-POS_W){y_ff[POS_W-1]}}, y_ff};
   assign old_x_ext = {{(SUM_W-POS_W){ram_rdata[POS_W-1]}}, ram_rdata[POS_W-1:0]};
   assign old_y_ext = {{(SUM_W-POS_W){ram_rdata[2*POS_W-1]}}, ram_rdata[2*POS_W-1:POS_W]};

   // ring slot for the next append
   assign app_idx   = AW'(oldest_ff) + AW'(count_ff);
   assign ram_waddr = (app_idx >= AW'(WINDOW_DEPTH)) ?
                      IDX_W'(app_idx - AW'(WINDOW_DEPTH)) : IDX_W'(app_idx);
   assign ram_we    = (state_ff == ST_APPEND);
   assign div_start = (state_ff == ST_DIV_GO);

   // sequence one item through the window
   always_comb begin
      state_in     = state_ff;
      mode_in      = mode_ff;
      min_iv_in    = min_iv_ff;
      max_cnt_in   = max_cnt_ff;
      count_in     = count_ff;
      oldest_in    = oldest_ff;
      sum_x_in     = sum_x_ff;
      sum_y_in     = sum_y_ff;
      cur_in       = cur_ff;
      last_in      = last_ff;
      cmd_in       = cmd_ff;
      elapsed_in   = elapsed_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      acc_in       = acc_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_acc_in   = rsp_acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      // register writes; a mode write empties the window
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in   = csr_wdata[MODE_W-1:0];
               count_in  = '0;
               oldest_in = '0;
               sum_x_in  = '0;
               sum_y_in  = '0;
            end
            CSR_MIN_INTERVAL: min_iv_in  = csr_wdata[MINIV_W-1:0];
            CSR_MAX_COUNT:    max_cnt_in = csr_wdata[MAXCNT_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_in     = req_tuser;
               elapsed_in = req_tdata[ELAPSED_W-1:0];
               x_in       = req_tdata[ELAPSED_W+POS_W-1:ELAPSED_W];
               y_in       = req_tdata[ELAPSED_W+2*POS_W-1:ELAPSED_W+POS_W];
               state_in   = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (cmd_ff == CMD_CLEAR) begin
               count_in  = '0;
               oldest_in = '0;
               sum_x_in  = '0;
               sum_y_in  = '0;
               acc_in    = 1'b0;
               res_x_in  = '0;
               res_y_in  = '0;
               state_in  = ST_WAIT_OUT;
            end else if (count_ff == '0) begin
               // first sample after a clear
               if (mode_ff == MODE_AVERAGE) begin
                  cur_in  = '0;
                  last_in = '0;
               end
               acc_in   = 1'b1;
               state_in = ST_APPEND;
            end else if (mode_ff == MODE_AVERAGE) begin
               cur_in   = cur_ff + TIME_W'(elapsed_ff);
               acc_in   = 1'b0;
               state_in = ST_TIME;
            end else begin
               acc_in   = 1'b0;
               state_in = ST_DIV_GO;
            end
         end
         ST_TIME: begin
            if (time_gap >= TIME_W'(min_iv_ff)) begin
               last_in  = last_ff + TIME_W'(min_iv_ff);
               acc_in   = 1'b1;
               state_in = ST_TRIM_CHK;
            end else begin
               state_in = ST_DIV_GO;
            end
         end
         ST_TRIM_CHK: begin
            // memory reads the oldest slot this cycle
            state_in = (count_ff >= limit) ? ST_TRIM_ACC : ST_APPEND;
         end
         ST_TRIM_ACC: begin
            sum_x_in  = sum_x_ff - old_x_ext;
            sum_y_in  = sum_y_ff - old_y_ext;
            oldest_in = (oldest_ff == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_ff + 1'b1;
            count_in  = count_ff - 1'b1;
            state_in  = ST_TRIM_CHK;
         end
         ST_APPEND: begin
            sum_x_in = sum_x_ff + x_ext;
            sum_y_in = sum_y_ff + y_ext;
            count_in = count_ff + 1'b1;
            state_in = ST_DIV_GO;
         end
         ST_DIV_GO: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_x_done) begin
               res_x_in = div_x_q;
               res_y_in = div_y_q;
               state_in = ST_WAIT_OUT;
            end
         end
         ST_WAIT_OUT: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_acc_in   = acc_ff;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= MODE_RESET;
         min_iv_ff    <= MIN_INTERVAL_RESET;
         max_cnt_ff   <= MAX_COUNT_RESET;
         count_ff     <= '0;
         oldest_ff    <= '0;
         sum_x_ff     <= '0;
         sum_y_ff     <= '0;
         cur_ff       <= '0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         min_iv_ff    <= min_iv_in;
         max_cnt_ff   <= max_cnt_in;
         count_ff     <= count_in;
         oldest_ff    <= oldest_in;
         sum_x_ff     <= sum_x_in;
         sum_y_ff     <= sum_y_in;
         cur_ff       <= cur_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff     <= cmd_in;
      elapsed_ff <= elapsed_in;
      x_ff       <= x_in;
      y_ff       <= y_in;
      acc_ff     <= acc_in;
      res_x_ff   <= res_x_in;
      res_y_ff   <= res_y_in;
      rsp_x_ff   <= rsp_x_in;
      rsp_y_ff   <= rsp_y_in;
      rsp_acc_ff <= rsp_acc_in;
   end

   // sample ring, y in the upper half
   twpa_ram #(
      .WIDTH (2 * POS_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata ({y_ff, x_ff}),
      .raddr (oldest_ff),
      .rdata (ram_rdata)
   );

   // window sum over entry count, one lane per axis
   twpa_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_x_ff),
      .divisor  (count_ff),
      .done     (div_x_done),
      .quotient (div_x_q)
   );

   twpa_div #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_y_ff),
      .divisor  (count_ff),
      .done     (div_y_done),
      .quotient (div_y_q)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_y_ff, rsp_x_ff};
   assign rsp_tuser  = rsp_acc_ff;

   // window never holds more than its depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("window entry count exceeds depth");

   // both divide lanes finish together, only while waiting on them
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      (div_x_done || div_y_done) |-> (div_x_done && div_y_done && state_ff == ST_DIV_WAIT))
      else $error("divider lanes out of step");

   // a drop only happens on a non-empty window
   a_trim_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRIM_ACC) |-> (count_ff != '0))
      else $error("drop from an empty window");

   // a pending result is never overwritten
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WAIT_OUT && rsp_valid_ff && !rsp_tready) |=> (state_ff == ST_WAIT_OUT))
      else $error("result loaded over a stalled beat");

   // an append grows the window by one unless a register write coincides
   a_append_grow: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_APPEND && !csr_we) |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("append did not grow the window");

endmodule

[dv/tb_timed_window_position_average.sv]
`timescale 1ns / 1ps

module tb_timed_window_position_average;
   import twpa_pkg::*;

   localparam int DEPTH         = DEF_WINDOW_DEPTH;
   localparam int STALL_MAX     = 15;
   localparam int STUCK_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 4;
   localparam int DRAIN_CYCLES  = 200;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int EXPECT_SLOTS  = 64;

   // index outside the register map, written once to show it is ignored
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam logic signed [POS_W-1:0] POS_MAX = 32'sh7fff_ffff;
   localparam logic signed [POS_W-1:0] POS_MIN = 32'sh8000_0000;

   typedef struct {
      logic signed [POS_W-1:0] avg_x;
      logic signed [POS_W-1:0] avg_y;
      logic                    accepted;
   } smooth_pos_type;

   logic                 clock      = 1'b0;
   logic                 reset      = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata  = '0;  // elapsed, target_x, target_y
   logic                 req_tuser  = CMD_PUSH;  // cmd
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [63:0]          rsp_tdata;  // avg_x, avg_y
   logic                 rsp_tuser;  // accepted
   logic                 csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [CSR_DAT_W-1:0] csr_wdata  = '0;

   // sample window as the block should hold it
   logic signed [POS_W-1:0] ring_x [DEPTH];
   logic signed [POS_W-1:0] ring_y [DEPTH];
   int unsigned             ring_fill;
   int unsigned             ring_head;
   longint                  ring_sum_x;
   longint                  ring_sum_y;
   logic [TIME_W-1:0]       now_time;
   logic [TIME_W-1:0]       mark_time;
   logic [MODE_W-1:0]       cur_mode;
   logic [MINIV_W-1:0]      cur_min_gap;
   logic [MAXCNT_W-1:0]     cur_max_keep;

   // expected results in order, written at accept and read at each result beat
   smooth_pos_type expect_ring [EXPECT_SLOTS];
   int unsigned    expect_wr   = 0;
   int unsigned    expect_rd   = 0;
   int             error_count = 0;
   int             beats_seen  = 0;
   int             idle_cycles = 0;
   bit             calm        = 1'b0;  // no gaps and no stalls while set

   timed_window_position_average u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic void empty_ring();
      ring_fill  = 0;
      ring_head  = 0;
      ring_sum_x = 0;
      ring_sum_y = 0;
   endfunction

   function automatic void ring_append(logic signed [POS_W-1:0] px,
                                       logic signed [POS_W-1:0] py);
      int unsigned slot;
      slot         = (ring_head + ring_fill) % DEPTH;
      ring_x[slot] = px;
      ring_y[slot] = py;
      ring_sum_x  += px;
      ring_sum_y  += py;
      ring_fill++;
   endfunction

   function automatic smooth_pos_type smooth_step(logic cmd, logic [ELAPSED_W-1:0] dt,
                                                  logic signed [POS_W-1:0] px,
                                                  logic signed [POS_W-1:0] py);
      smooth_pos_type    res;
      logic [TIME_W-1:0] since;
      int unsigned       keep;
      longint            qx;
      longint            qy;
      res.avg_x    = '0;
      res.avg_y    = '0;
      res.accepted = 1'b0;
      if (cmd == CMD_CLEAR) begin
         empty_ring();
         return res;
      end
      if (ring_fill == 0) begin
         // first sample after a clear; restart both clocks in average mode
         ring_append(px, py);
         if (cur_mode == MODE_AVERAGE) begin
            now_time  = '0;
            mark_time = '0;
         end
         res.accepted = 1'b1;
      end else if (cur_mode == MODE_AVERAGE) begin
         now_time = now_time + TIME_W'(dt);
         since    = now_time - mark_time;
         if (since >= TIME_W'(cur_min_gap)) begin
            keep = cur_max_keep;
            if (keep < 1) keep = 1;
            if (keep > DEPTH) keep = DEPTH;
            // drop oldest entries until the new one fits
            while (ring_fill >= keep) begin
               ring_sum_x -= ring_x[ring_head];
               ring_sum_y -= ring_y[ring_head];
               ring_head   = (ring_head + 1) % DEPTH;
               ring_fill--;
            end
            ring_append(px, py);
            mark_time    = mark_time + TIME_W'(cur_min_gap);
            res.accepted = 1'b1;
         end
      end
      // truncating divide; a single entry passes the sum through
      if (ring_fill > 1) begin
         qx = ring_sum_x / longint'(ring_fill);
         qy = ring_sum_y / longint'(ring_fill);
      end else begin
         qx = ring_sum_x;
         qy = ring_sum_y;
      end
      res.avg_x = qx[POS_W-1:0];
      res.avg_y = qy[POS_W-1:0];
      return res;
   endfunction

   // ---------------------------------------------------------------- drivers

   // send one request beat and record what it should produce
   task automatic send_beat(input logic cmd, input logic [ELAPSED_W-1:0] dt,
                            input logic signed [POS_W-1:0] px,
                            input logic signed [POS_W-1:0] py);
      int gap;
      gap = calm ? 0 : $urandom_range(0, STALL_MAX);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {py, px, dt};
      do @(posedge clock); while (!req_tready);
      expect_ring[expect_wr % EXPECT_SLOTS] = smooth_step(cmd, dt, px, py);
      expect_wr++;
   endtask

   task automatic push(input logic [ELAPSED_W-1:0] dt, input logic signed [POS_W-1:0] px,
                       input logic signed [POS_W-1:0] py);
      send_beat(CMD_PUSH, dt, px, py);
   endtask

   // hold the request side until every result is back, then let the block settle
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expect_wr != expect_rd) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // the block must be idle here
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      case (idx)
         CSR_MODE: begin
            cur_mode = val[MODE_W-1:0];
            empty_ring();
         end
         CSR_MIN_INTERVAL: cur_min_gap  = val[MINIV_W-1:0];
         CSR_MAX_COUNT:    cur_max_keep = val[MAXCNT_W-1:0];
         default: ;
      endcase
   endtask

   function automatic logic signed [POS_W-1:0] rand_pos();
      case ($urandom_range(0, 7))
         0:       return POS_MAX;
         1:       return POS_MIN;
         2:       return $urandom_range(0, 131072) - 65536;
         default: return $urandom;
      endcase
   endfunction

   // mostly around the sampling interval so that samples land often
   function automatic logic [ELAPSED_W-1:0] rand_elapsed();
      int span;
      span = 2 * int'(cur_min_gap) + 1;
      if (span > 65535) span = 65535;
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2:       return ELAPSED_W'($urandom);
         default: return ELAPSED_W'($urandom_range(0, span));
      endcase
   endfunction

   // ---------------------------------------------------------------- result side

   // stall the response side a random number of cycles per beat
   initial begin : take_results
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, STALL_MAX);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && !reset));
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch on result %0d: %s", $realtime, beats_seen, msg);
      error_count++;
   endtask

   // compare each result beat with the oldest expectation
   always @(posedge clock) begin : check_results
      smooth_pos_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expect_wr == expect_rd) begin
            report_mismatch($sformatf("beat with nothing expected, tdata %h tuser %b",
                                      rsp_tdata, rsp_tuser));
         end else begin
            want = expect_ring[expect_rd % EXPECT_SLOTS];
            expect_rd++;
            if (rsp_tdata[31:0] !== want.avg_x)
               report_mismatch($sformatf("avg_x got %h want %h", rsp_tdata[31:0], want.avg_x));
            if (rsp_tdata[63:32] !== want.avg_y)
               report_mismatch($sformatf("avg_y got %h want %h", rsp_tdata[63:32], want.avg_y));
            if (rsp_tuser !== want.accepted)
               report_mismatch($sformatf("accepted got %b want %b", rsp_tuser, want.accepted));
         end
         beats_seen++;
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STUCK_LIMIT) begin
         $display("timed_window_position_average regression: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- tests

   // reset settings: first sample, interval gating, catch-up and clear
   task automatic test_first_samples();
      push(16'd0, POS_MAX, POS_MIN);
      push(16'd49, 32'sd1, 32'sd1);
      push(16'd1, 32'sd1, 32'sd1);
      push(16'hFFFF, -32'sd1, -32'sd1);
      repeat (3) push(16'd0, rand_pos(), rand_pos());
      send_beat(CMD_CLEAR, 16'hFFFF, POS_MAX, POS_MAX);
      push(16'hFFFF, POS_MIN, POS_MAX);
      push(16'd10, rand_pos(), rand_pos());
   endtask

   // window size extremes, clamping of the limit, unused index, widest interval
   task automatic test_limits();
      drain_results();
      write_csr(CSR_MAX_COUNT, 16'd1);
      write_csr(CSR_MIN_INTERVAL, 16'd0);
      repeat (3) push(16'd0, POS_MIN, POS_MAX);
      drain_results();
      write_csr(CSR_MAX_COUNT, 16'd0);
      repeat (2) push(16'd0, rand_pos(), rand_pos());
      drain_results();
      write_csr(CSR_MAX_COUNT, 16'd127);
      repeat (2) push(16'd0, rand_pos(), rand_pos());
      drain_results();
      write_csr(CSR_UNUSED, 16'hFFFF);
      push(16'd0, rand_pos(), rand_pos());
      drain_results();
      write_csr(CSR_MIN_INTERVAL, 16'hFFFF);
      push(16'hFFFF, POS_MAX, POS_MIN);
      push(16'hFFFE, rand_pos(), rand_pos());
   endtask

   // keep-first mode: store once, echo, clear, store again
   task automatic test_first_only();
      drain_results();
      write_csr(CSR_MODE, CSR_DAT_W'(MODE_FIRST_ONLY));
      push(16'hFFFF, rand_pos(), rand_pos());
      push(16'hFFFF, rand_pos(), rand_pos());
      push(16'd0, rand_pos(), rand_pos());
      send_beat(CMD_CLEAR, 16'd0, rand_pos(), rand_pos());
      push(16'd7, POS_MIN, POS_MIN);
      push(16'd7, rand_pos(), rand_pos());
      drain_results();
      write_csr(CSR_MODE, CSR_DAT_W'(MODE_AVERAGE));
      push(16'd3, rand_pos(), rand_pos());
   endtask

   // phases of random items under changing settings
   task automatic test_random();
      int  phase;
      int  sent;
      int  count;
      bit  pinned;
      logic signed [POS_W-1:0] pin_val;
      phase = 0;
      sent  = 0;
      while (sent < RANDOM_ITEMS) begin
         drain_results();
         pinned  = ($urandom_range(0, 4) == 0);
         pin_val = $urandom_range(0, 1) ? POS_MAX : POS_MIN;
         count   = $urandom_range(20, 120);
         if (phase == 0) begin
            // fill the whole window with the most negative value
            write_csr(CSR_MODE, CSR_DAT_W'(MODE_AVERAGE));
            write_csr(CSR_MIN_INTERVAL, 16'd0);
            write_csr(CSR_MAX_COUNT, 16'(DEPTH));
            pinned  = 1'b1;
            pin_val = POS_MIN;
            count   = DEPTH + 16;
         end else if (phase == 1) begin
            // shrink a full window to one entry in one step
            write_csr(CSR_MAX_COUNT, 16'd1);
         end else begin
            if ($urandom_range(0, 5) == 0) begin
               write_csr(CSR_MODE, CSR_DAT_W'(MODE_FIRST_ONLY));
            end else if (cur_mode == MODE_FIRST_ONLY || $urandom_range(0, 3) == 0) begin
               write_csr(CSR_MODE, CSR_DAT_W'(MODE_AVERAGE));
            end
            case ($urandom_range(0, 5))
               0:       write_csr(CSR_MIN_INTERVAL, 16'd0);
               1:       write_csr(CSR_MIN_INTERVAL, 16'd1);
               2:       write_csr(CSR_MIN_INTERVAL, 16'hFFFF);
               default: write_csr(CSR_MIN_INTERVAL, 16'($urandom_range(2, 200)));
            endcase
            case ($urandom_range(0, 5))
               0:       write_csr(CSR_MAX_COUNT, 16'd1);
               1:       write_csr(CSR_MAX_COUNT, 16'(DEPTH));
               2:       write_csr(CSR_MAX_COUNT, 16'd2);
               default: write_csr(CSR_MAX_COUNT, 16'($urandom_range(1, DEPTH)));
            endcase
         end
         calm = ($urandom_range(0, 3) == 0);
         repeat (count) begin
            if ($urandom_range(0, 39) == 0) begin
               send_beat(CMD_CLEAR, ELAPSED_W'($urandom), rand_pos(), rand_pos());
            end else if (pinned) begin
               push(rand_elapsed(), pin_val, pin_val);
            end else begin
               push(rand_elapsed(), rand_pos(), rand_pos());
            end
            sent++;
         end
         phase++;
      end
      calm = 1'b0;
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      cur_mode     = MODE_RESET;
      cur_min_gap  = MIN_INTERVAL_RESET;
      cur_max_keep = MAX_COUNT_RESET;
      now_time     = '0;
      mark_time    = '0;
      empty_ring();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_first_samples();
      test_limits();
      test_first_only();
      test_random();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("timed_window_position_average regression: pass");
      end else begin
         $display("timed_window_position_average regression: fail");
      end
      $finish;
   end

endmodule
